// File: hdl/jsu_pkg.sv
package jsu_pkg;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_TEXT = 2'd1,
		PH_ESC  = 2'd2,
		PH_HEX  = 2'd3
	} phase_t;

	localparam logic [2:0] KIND_BYTE  = 3'd0;
	localparam logic [2:0] KIND_DONE  = 3'd1;
	localparam logic [2:0] KIND_BREAK = 3'd2;
	localparam logic [2:0] KIND_BADU  = 3'd3;
	localparam logic [2:0] KIND_OPEN  = 3'd4;

	// All results caused by one input byte: up to three decoded bytes,
	// then an optional terminal report.
	typedef struct packed {
		logic [1:0]      nbytes;
		logic [2:0][7:0] bytes;
		logic            has_term;
		logic [2:0]      term_kind;
	} work_t;

endpackage

// File: hdl/jsu_front.sv
module jsu_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        text_byte,
	input  logic              end_of_text,
	output logic              push,
	output jsu_pkg::work_t    work
);

	jsu_pkg::phase_t phase_q, nxt_phase;
	logic [1:0]      hex_count_q, nxt_hex_count;
	logic [15:0]     code_point_q, nxt_code_point;

	logic            hex_ok;
	logic [3:0]      hex_digit;
	logic [15:0]     cp_new;
	logic [7:0]      esc_byte;

	always_comb begin
		hex_ok    = 1'b1;
		hex_digit = 4'd0;
		if (text_byte >= 8'h30 && text_byte <= 8'h39) begin
			hex_digit = 4'(text_byte - 8'h30);
		end else if (text_byte >= 8'h61 && text_byte <= 8'h66) begin
			hex_digit = 4'(text_byte - 8'h57);
		end else if (text_byte >= 8'h41 && text_byte <= 8'h46) begin
			hex_digit = 4'(text_byte - 8'h37);
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign cp_new = {code_point_q[11:0], hex_digit};

	always_comb begin
		case (text_byte)
			8'h6e: esc_byte = 8'h0a;
			8'h74: esc_byte = 8'h09;
			8'h72: esc_byte = 8'h0d;
			8'h62: esc_byte = 8'h08;
			8'h66: esc_byte = 8'h0c;
			default: esc_byte = text_byte;
		endcase
	end

	always_comb begin
		nxt_phase      = phase_q;
		nxt_hex_count  = hex_count_q;
		nxt_code_point = code_point_q;
		work           = '0;
		case (phase_q)
			jsu_pkg::PH_IDLE: begin
				nxt_phase = jsu_pkg::PH_TEXT;
				if (end_of_text) begin
					work.has_term  = 1'b1;
					work.term_kind = jsu_pkg::KIND_OPEN;
				end
			end
			jsu_pkg::PH_TEXT: begin
				if (text_byte == 8'h22) begin
					work.has_term  = 1'b1;
					work.term_kind = jsu_pkg::KIND_DONE;
				end else if (text_byte == 8'h0a) begin
					work.has_term  = 1'b1;
					work.term_kind = jsu_pkg::KIND_BREAK;
				end else begin
					if (text_byte == 8'h5c) begin
						nxt_phase = jsu_pkg::PH_ESC;
					end else begin
						work.nbytes   = 2'd1;
						work.bytes[0] = text_byte;
					end
					if (end_of_text) begin
						work.has_term  = 1'b1;
						work.term_kind = jsu_pkg::KIND_OPEN;
					end
				end
			end
			jsu_pkg::PH_ESC: begin
				if (text_byte == 8'h75) begin
					nxt_phase      = jsu_pkg::PH_HEX;
					nxt_hex_count  = 2'd0;
					nxt_code_point = 16'd0;
					if (end_of_text) begin
						work.has_term  = 1'b1;
						work.term_kind = jsu_pkg::KIND_BADU;
					end
				end else begin
					nxt_phase     = jsu_pkg::PH_TEXT;
					work.nbytes   = 2'd1;
					work.bytes[0] = esc_byte;
					if (end_of_text) begin
						work.has_term  = 1'b1;
						work.term_kind = jsu_pkg::KIND_OPEN;
					end
				end
			end
			default: begin
				if (!hex_ok) begin
					work.has_term  = 1'b1;
					work.term_kind = jsu_pkg::KIND_BADU;
				end else if (hex_count_q != 2'd3) begin
					nxt_hex_count  = hex_count_q + 2'd1;
					nxt_code_point = cp_new;
					if (end_of_text) begin
						work.has_term  = 1'b1;
						work.term_kind = jsu_pkg::KIND_BADU;
					end
				end else begin
					nxt_phase      = jsu_pkg::PH_TEXT;
					nxt_hex_count  = 2'd0;
					nxt_code_point = 16'd0;
					if (cp_new < 16'h0080) begin
						work.nbytes   = 2'd1;
						work.bytes[0] = cp_new[7:0];
					end else if (cp_new < 16'h0800) begin
						work.nbytes   = 2'd2;
						work.bytes[0] = 8'hc0 | {3'd0, cp_new[10:6]};
						work.bytes[1] = 8'h80 | {2'd0, cp_new[5:0]};
					end else begin
						work.nbytes   = 2'd3;
						work.bytes[0] = 8'he0 | {4'd0, cp_new[15:12]};
						work.bytes[1] = 8'h80 | {2'd0, cp_new[11:6]};
						work.bytes[2] = 8'h80 | {2'd0, cp_new[5:0]};
					end
					if (end_of_text) begin
						work.has_term  = 1'b1;
						work.term_kind = jsu_pkg::KIND_OPEN;
					end
				end
			end
		endcase
		// any terminal report drops back to waiting for a new token
		if (work.has_term) begin
			nxt_phase      = jsu_pkg::PH_IDLE;
			nxt_hex_count  = 2'd0;
			nxt_code_point = 16'd0;
		end
	end

	assign push = accept && (work.has_term || work.nbytes != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= jsu_pkg::PH_IDLE;
			hex_count_q  <= 2'd0;
			code_point_q <= 16'd0;
		end else if (accept) begin
			phase_q      <= nxt_phase;
			hex_count_q  <= nxt_hex_count;
			code_point_q <= nxt_code_point;
		end
	end

endmodule

// File: hdl/jsu_queue.sv
module jsu_queue #(
	parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  jsu_pkg::work_t push_data,
	output logic           full,
	input  logic           pop,
	output jsu_pkg::work_t pop_data,
	output logic           nempty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	jsu_pkg::work_t  entries_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign nempty   = (count_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && nempty;
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: hdl/jsu_back.sv
module jsu_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           nempty,
	input  jsu_pkg::work_t head,
	output logic           pop,
	output logic           result_valid,
	input  logic           result_ready,
	output logic [7:0]     out_byte,
	output logic [2:0]     kind,
	output logic           run_last
);

	logic [1:0] idx_q;
	logic [2:0] total;
	logic       load, is_byte, is_last;
	logic [7:0] sel_byte;
	logic       valid_q;
	logic [7:0] byte_q;
	logic [2:0] kind_q;
	logic       last_q;

	assign total   = {1'b0, head.nbytes} + {2'd0, head.has_term};
	assign is_byte = (idx_q < head.nbytes);
	assign is_last = ({1'b0, idx_q} + 3'd1 == total);
	assign load    = nempty && (!valid_q || result_ready);
	assign pop     = load && is_last;

	always_comb begin
		case (idx_q)
			2'd0: sel_byte = head.bytes[0];
			2'd1: sel_byte = head.bytes[1];
			2'd2: sel_byte = head.bytes[2];
			default: sel_byte = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= is_byte ? sel_byte : 8'd0;
			kind_q <= is_byte ? jsu_pkg::KIND_BYTE : head.term_kind;
			last_q <= is_last;
		end
	end

	assign result_valid = valid_q;
	assign out_byte     = byte_q;
	assign kind         = kind_q;
	assign run_last     = last_q;

	a_term_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind != jsu_pkg::KIND_BYTE) |-> run_last)
		else $error("terminal report not marked last");

	a_term_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind != jsu_pkg::KIND_BYTE) |-> (out_byte == 8'd0))
		else $error("terminal report carries a byte");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nempty)
		else $error("pop from empty queue");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		nempty |-> ({1'b0, idx_q} < total))
		else $error("result index past end of queued request");

endmodule

// File: hdl/json_string_unescaper_unit.sv
// Channel  | Handshake                   | Payload
// text     | text_valid / text_ready     | text_byte[7:0], end_of_text
// result   | result_valid / result_ready | out_byte[7:0], kind[2:0], run_last
//
// Takes one request per cycle while the queue has room; the front decoder updates
// its state in the cycle of acceptance and queues every result that the byte causes.
// The back end sends one result per cycle while result_ready allows; a request with n
// results holds it for all n (up to 4 for a three-byte \u escape that ends the input).
// The first result is held in the queue, then in the back end output register.
// Reset clears decoder state, queue pointers and the output valid; no clearing pass.
module json_string_unescaper_unit #(
	parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_ready,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [7:0] out_byte,
	output logic [2:0] kind,
	output logic       run_last
);

	jsu_pkg::work_t work, head;
	logic           push, full, pop, nempty, accept;

	assign text_ready = !full;
	assign accept     = text_valid && text_ready;

	jsu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.push        (push),
		.work        (work)
	);

	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (work),
		.full      (full),
		.pop       (pop),
		.pop_data  (head),
		.nempty    (nempty)
	);

	jsu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.nempty       (nempty),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_byte     (out_byte),
		.kind         (kind),
		.run_last     (run_last)
	);

endmodule

// File: tb/testbench.sv
module testbench;

	localparam logic [7:0] QUOTE  = 8'h22;
	localparam logic [7:0] BSLASH = 8'h5c;
	localparam logic [7:0] LF     = 8'h0a;
	localparam int PHASE_ITEMS  = 70;
	localparam int DRAIN_CYCLES = 16;

	typedef logic [7:0] bytes_t[$];

	typedef struct packed {
		logic [7:0] b;
		logic [2:0] k;
		logic       last;
	} res_t;

	class unescape_scoreboard;
		jsu_pkg::phase_t ph = jsu_pkg::PH_IDLE;
		logic [1:0] ndig = '0;
		logic [15:0] cp = '0;
		res_t       fresh_q[$];
		res_t       want_q[$];
		int         errors = 0;

		function int pending();
			return want_q.size();
		endfunction

		function void add_byte(input logic [7:0] b);
			fresh_q.insert(fresh_q.size(), '{b: b, k: jsu_pkg::KIND_BYTE, last: 1'b0});
		endfunction

		// terminal report: always drops back to awaiting a new token
		function void report(input logic [2:0] k);
			fresh_q.insert(fresh_q.size(), '{b: 8'h00, k: k, last: 1'b0});
			ph = jsu_pkg::PH_IDLE;
			ndig = '0;
			cp = '0;
		endfunction

		function bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
			v = '0;
			if (c >= "0" && c <= "9") begin
				v = 4'(c - "0");
				return 1'b1;
			end
			if (c >= "a" && c <= "f") begin
				v = 4'(c - "a" + 10);
				return 1'b1;
			end
			if (c >= "A" && c <= "F") begin
				v = 4'(c - "A" + 10);
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_request(input logic [7:0] c, input logic eot);
			logic [3:0] nib;
			logic [7:0] b;
			logic [15:0] v;
			fresh_q.delete();
			case (ph)
				jsu_pkg::PH_IDLE: begin
					ph = jsu_pkg::PH_TEXT;
					if (eot) report(jsu_pkg::KIND_OPEN);
				end
				jsu_pkg::PH_TEXT: begin
					if (c == QUOTE) report(jsu_pkg::KIND_DONE);
					else if (c == LF) report(jsu_pkg::KIND_BREAK);
					else begin
						if (c == BSLASH) ph = jsu_pkg::PH_ESC;
						else add_byte(c);
						if (eot) report(jsu_pkg::KIND_OPEN);
					end
				end
				jsu_pkg::PH_ESC: begin
					if (c == "u") begin
						ph = jsu_pkg::PH_HEX;
						ndig = '0;
						cp = '0;
						if (eot) report(jsu_pkg::KIND_BADU);
					end else begin
						case (c)
							"n": b = 8'h0a;
							"t": b = 8'h09;
							"r": b = 8'h0d;
							"b": b = 8'h08;
							"f": b = 8'h0c;
							default: b = c;
						endcase
						add_byte(b);
						ph = jsu_pkg::PH_TEXT;
						if (eot) report(jsu_pkg::KIND_OPEN);
					end
				end
				default: begin
					if (!hex_nibble(c, nib)) report(jsu_pkg::KIND_BADU);
					else begin
						cp = {cp[11:0], nib};
						if (ndig != 2'd3) begin
							ndig++;
							if (eot) report(jsu_pkg::KIND_BADU);
						end else begin
							v = cp;
							if (v < 16'h0080) add_byte(v[7:0]);
							else if (v < 16'h0800) begin
								add_byte(8'hc0 | {3'b000, v[10:6]});
								add_byte(8'h80 | {2'b00, v[5:0]});
							end else begin
								add_byte(8'he0 | {4'h0, v[15:12]});
								add_byte(8'h80 | {2'b00, v[11:6]});
								add_byte(8'h80 | {2'b00, v[5:0]});
							end
							ph = jsu_pkg::PH_TEXT;
							ndig = '0;
							cp = '0;
							if (eot) report(jsu_pkg::KIND_OPEN);
						end
					end
				end
			endcase
			if (fresh_q.size() != 0) fresh_q[fresh_q.size() - 1].last = 1'b1;
			foreach (fresh_q[i]) want_q.insert(want_q.size(), fresh_q[i]);
		endfunction

		function void flag(input string msg);
			errors++;
			if (errors <= 10) $display("mismatch: %s", msg);
		endfunction

		function void check_result(input logic [7:0] b, input logic [2:0] k, input logic l);
			res_t w;
			if (want_q.size() == 0) begin
				flag($sformatf("unexpected result byte=%h kind=%0d last=%b", b, k, l));
				return;
			end
			w = want_q.pop_front();
			if (w.b !== b || w.k !== k || w.last !== l)
				flag($sformatf("expected byte=%h kind=%0d last=%b, got byte=%h kind=%0d last=%b",
					w.b, w.k, w.last, b, k, l));
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       text_valid = 1'b0;
	logic       text_ready;
	logic [7:0] text_byte = '0;
	logic       end_of_text = 1'b0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	logic [7:0] out_byte;
	logic [2:0] kind;
	logic       run_last;

	unescape_scoreboard sb;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int sent = 0;

	json_string_unescaper_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_ready(text_ready),
		.text_byte(text_byte),
		.end_of_text(end_of_text),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.out_byte(out_byte),
		.kind(kind),
		.run_last(run_last)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (text_valid && text_ready) sb.note_request(text_byte, end_of_text);
			if (result_valid && result_ready) sb.check_result(out_byte, kind, run_last);
		end
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic e);
		while ($urandom_range(99) < send_idle_pct) begin
			text_valid <= 1'b0;
			@(posedge clk);
		end
		text_valid <= 1'b1;
		text_byte <= b;
		end_of_text <= e;
		do @(posedge clk); while (!text_ready);
		sent++;
	endtask

	task automatic send_seq(input bytes_t seq, input bit eot_last);
		foreach (seq[i]) send_byte(seq[i], eot_last && i == seq.size() - 1);
	endtask

	// hold the sender until every expected result is out
	task automatic drain();
		text_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) return 8'("0" + v);
		return 8'(($urandom_range(1) ? "a" : "A") + v - 10);
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (b == QUOTE || b == BSLASH || b == LF);
		return b;
	endfunction

	function automatic bytes_t random_piece();
		bytes_t p;
		logic [15:0] v;
		logic [7:0] b;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: p = {p, plain_byte()};
			5, 6: begin
				p = {p, BSLASH};
				case ($urandom_range(7))
					0: b = "n";
					1: b = "t";
					2: b = "r";
					3: b = "b";
					4: b = "f";
					5: b = QUOTE;
					6: b = BSLASH;
					default: begin
						do b = 8'($urandom); while (b == "u");
					end
				endcase
				p = {p, b};
			end
			default: begin
				case ($urandom_range(2))
					0: v = 16'($urandom_range(16'h007f));
					1: v = 16'($urandom_range(16'h07ff, 16'h0080));
					default: v = 16'($urandom_range(16'hffff, 16'h0800));
				endcase
				p = {p, BSLASH};
				p = {p, 8'h75};
				for (int i = 3; i >= 0; i--) p = {p, hex_char(v[i*4 +: 4])};
			end
		endcase
		return p;
	endfunction

	// mostly well-formed tokens; a few end in each error way or in noise
	task automatic random_token();
		bytes_t seq;
		bit eot_last;
		int ending;
		logic [7:0] b;
		seq = {seq, QUOTE};
		repeat ($urandom_range(5)) seq = {seq, random_piece()};
		ending = $urandom_range(19);
		eot_last = 1'b1;
		case (ending)
			12: begin
				seq = {seq, LF};
				eot_last = 1'($urandom_range(1));
			end
			13: begin
				seq = {seq, BSLASH};
				seq = {seq, 8'h75};
				repeat ($urandom_range(3)) seq = {seq, hex_char(4'($urandom))};
				do b = 8'($urandom);
				while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
				seq = {seq, b};
				eot_last = 1'($urandom_range(1));
			end
			14: begin
				seq = {seq, BSLASH};
				seq = {seq, 8'h75};
				repeat ($urandom_range(3)) seq = {seq, hex_char(4'($urandom))};
			end
			15: seq = {seq, BSLASH};
			16, 17: seq = {seq, random_piece()};
			18, 19: repeat ($urandom_range(6, 1)) seq = {seq, 8'($urandom)};
			default: begin
				seq = {seq, QUOTE};
				eot_last = ($urandom_range(3) == 0);
			end
		endcase
		send_seq(seq, eot_last);
	endtask

	initial begin
		int phase_start;
		sb = new;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 86; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 86; end
				default: begin send_idle_pct = 38; stall_pct = 38; end
			endcase
			if (p == 0) begin
				send_seq({8'h00, 8'hff, BSLASH, "t", BSLASH, "u", "F", "F", "F", "F"}, 1'b1);
				send_seq({QUOTE, "a", BSLASH, "u", "0", "0", "e", "9", QUOTE}, 1'b0);
				send_seq({QUOTE, LF}, 1'b0);
				send_seq({QUOTE, BSLASH, "u"}, 1'b1);
				send_seq({QUOTE, BSLASH}, 1'b1);
				send_seq({QUOTE, BSLASH, "u", "g"}, 1'b0);
				send_seq({QUOTE}, 1'b1);
				send_seq({QUOTE, QUOTE}, 1'b1);
			end
			phase_start = sent;
			while (sent - phase_start < PHASE_ITEMS) random_token();
			drain();
		end
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/jsu_pkg.sv
hdl/jsu_front.sv
hdl/jsu_queue.sv
hdl/jsu_back.sv
hdl/json_string_unescaper_unit.sv
tb/testbench.sv
